[rtl/block_access_working_set_sampler_assert.svh]
// Assertion macros for the working set sampler
`ifndef BLOCK_ACCESS_WORKING_SET_SAMPLER_ASSERT_SVH
`define BLOCK_ACCESS_WORKING_SET_SAMPLER_ASSERT_SVH
`define BAWS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BAWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[rtl/baws_pkg.sv]
// Package: types, constants and command structs for the working set sampler
package baws_pkg;
   localparam int ADDR_BITS = 16;
   localparam int TIME_BITS = 56;
   localparam int CNT_BITS = ADDR_BITS + 1;
   localparam logic [55:0] QUANTUM_RESET = 56'd2000000000;
   localparam logic [7:0] SECTORS_RESET = 8'd8;
   localparam logic [31:0] MAX32 = 32'hffff_ffff;
   localparam logic [0:0] CSR_QUANTUM = 1'b0;
   localparam logic [0:0] CSR_SECTORS = 1'b1;
   localparam logic [1:0] KIND_PERIODIC = 2'd0;
   localparam logic [1:0] KIND_FINAL = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;
   localparam logic [1:0] MARK_READ = 2'b01;
   localparam logic [1:0] MARK_WRITE = 2'b10;

   typedef struct packed {
      logic [0:0] mode;
      logic [55:0] time_stamp;
      logic [7:0] rw_tag;
      logic [15:0] block_address;
      logic [7:0] sector_count;
   } req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [31:0] first_sample;
      logic [31:0] sample_run;
      logic [31:0] unique_clean_sectors;
      logic [31:0] unique_dirty_sectors;
      logic [31:0] read_sectors;
      logic [31:0] write_sectors;
   } rsp_type;

   typedef struct packed {
      logic clear;      // clear one mark entry
      logic latch;      // capture request, issue mark read
      logic div_start;  // begin (d-1)/q
      logic div_step;   // one quotient bit
      logic update;     // apply record, decide result
      logic final_out;  // load final result
      logic scale;      // one scaling multiply step
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic is_final;
      logic is_error;
      logic need_div;
      logic div_done;
      logic emit;
      logic scale_done;
   } sts_type;
endpackage

[rtl/block_access_working_set_sampler.sv]
// Top level of the block access working set sampler
// One request at a time. After reset the mark memory is cleared one entry per
// cycle, all 65536 entries, with requests stalled. An access record with zero
// elapsed time goes straight to the update; with nonzero elapsed time a 56-step
// serial division of elapsed time minus one by the quantum comes first. When a
// sample result is produced, 4 scaling steps precede the update and the
// handoff, which can wait on result-side stall. A final or error request loads
// its result, scales it and shows it, then the block halts until reset; while
// halted, requests are accepted and dropped.
module block_access_working_set_sampler import baws_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_type rsp_data,
   input logic csr_valid,
   output logic csr_ready,
   input logic [0:0] csr_index,
   input logic [63:0] csr_data
);
   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   baws_control u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .cmd(cmd)
   );

   baws_datapath u_dp (
      .clock(clock), .reset(reset), .req_in(req_data), .csr_we(csr_valid),
      .csr_idx(csr_index), .csr_data(csr_data), .cmd(cmd), .sts(sts),
      .rsp_data(rsp_data)
   );
endmodule

[rtl/baws_datapath.sv]
// Datapath: mark memory, counters, serial divider and result scaling
module baws_datapath import baws_pkg::*; (
   input logic clock,
   input logic reset,
   input req_type req_in,
   input logic csr_we,
   input logic [0:0] csr_idx,
   input logic [63:0] csr_data,
   input cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_data
);
   logic [1:0] marks_mem [0:(1<<ADDR_BITS)-1];
   logic [ADDR_BITS-1:0] clr_ff;
   logic [1:0] mark_ff;
   req_type req_ff;
   logic [55:0] quantum_ff, start_ff, d_ff, rem_ff, q_ff;
   logic [55:0] quo_ff;
   logic [5:0] bit_ff;
   logic [31:0] index_ff, rd_ff, wr_ff;
   logic [CNT_BITS-1:0] clean_ff, dirty_ff;
   logic [7:0] spr_ff;
   logic [1:0] kind_ff;
   logic [31:0] first_ff, run_ff;
   logic [2:0] sc_ff;
   logic [31:0] res_ff [0:3];
   logic [ADDR_BITS-1:0] addr;
   logic [55:0] st_eff, dd, q_in;
   logic [56:0] rem_sh;
   logic [57:0] trial;
   logic [1:0] m;
   logic [56:0] run_w, next_w;
   logic [31:0] mul_src;
   logic [39:0] prod;

   assign addr = req_ff.block_address[ADDR_BITS-1:0];
   assign st_eff = (start_ff == '0) ? req_ff.time_stamp : start_ff;
   assign dd = req_ff.time_stamp - st_eff;
   assign q_in = (quantum_ff == '0) ? 56'd1 : quantum_ff;
   assign rem_sh = {rem_ff, d_ff[bit_ff]};
   assign trial = {1'b0, rem_sh} - {2'b00, q_ff};
   assign m = mark_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_in;
         mark_ff <= marks_mem[req_in.block_address[ADDR_BITS-1:0]];
      end
      if (cmd.clear) begin
         marks_mem[clr_ff] <= 2'b00;
      end else if (cmd.update && !sts.is_final && !sts.is_error) begin
         marks_mem[addr] <= m | ((req_ff.rw_tag != '0) ? MARK_WRITE : MARK_READ);
      end
   end

   always_comb begin
      run_w = {1'b0, quo_ff} - {25'd0, index_ff} + 57'd1;
      next_w = {1'b0, quo_ff} + 57'd1;
      if (run_w[56:32] != '0) run_w = {25'd0, MAX32};
      if (next_w[56:32] != '0) next_w = {25'd0, MAX32};
   end

   always_comb begin
      case (sc_ff)
         3'd0: mul_src = {{(32-CNT_BITS){1'b0}}, clean_ff};
         3'd1: mul_src = {{(32-CNT_BITS){1'b0}}, dirty_ff};
         3'd2: mul_src = rd_ff;
         default: mul_src = wr_ff;
      endcase
   end
   assign prod = mul_src * spr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= QUANTUM_RESET;
         spr_ff <= SECTORS_RESET;
         start_ff <= '0;
         index_ff <= 32'd1;
         clean_ff <= '0;
         dirty_ff <= '0;
         rd_ff <= '0;
         wr_ff <= '0;
         clr_ff <= '0;
         sc_ff <= '0;
      end else begin
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         if (csr_we) begin
            case (csr_idx)
               CSR_QUANTUM: quantum_ff <= csr_data[55:0];
               default: spr_ff <= csr_data[7:0];
            endcase
         end
         if (cmd.div_start) begin
            start_ff <= st_eff;
            d_ff <= dd - 56'd1;
            q_ff <= q_in;
            rem_ff <= '0;
            quo_ff <= '0;
            bit_ff <= 6'd55;
         end
         if (cmd.div_step) begin
            if (!trial[57]) rem_ff <= trial[55:0];
            else rem_ff <= rem_sh[55:0];
            quo_ff <= {quo_ff[54:0], ~trial[57]};
            bit_ff <= bit_ff - 6'd1;
         end
         if (cmd.update && !sts.is_final && !sts.is_error) begin
            start_ff <= st_eff;
            kind_ff <= KIND_PERIODIC;
            first_ff <= index_ff;
            run_ff <= run_w[31:0];
            if (sts.emit) index_ff <= next_w[31:0];
            if (req_ff.rw_tag != '0) begin
               wr_ff <= wr_ff + 32'd1;
               if (!m[1]) begin
                  dirty_ff <= dirty_ff + 1'b1;
                  if (m[0]) clean_ff <= clean_ff - 1'b1;
               end
            end else begin
               rd_ff <= rd_ff + 32'd1;
               if (m == 2'b00) clean_ff <= clean_ff + 1'b1;
            end
            sc_ff <= '0;
         end
         if (cmd.final_out) begin
            kind_ff <= sts.is_final ? KIND_FINAL : KIND_ERROR;
            first_ff <= index_ff;
            run_ff <= 32'd1;
            sc_ff <= '0;
         end
         if (cmd.scale) begin
            res_ff[sc_ff[1:0]] <= prod[31:0];
            sc_ff <= sc_ff + 3'd1;
         end
      end
   end

   // in the final path no update runs; in the periodic path the scaling is
   // done before the update, so scaling uses pre-update values
   always_comb begin
      sts.clear_done = (clr_ff == '1);
      sts.is_final = req_ff.mode[0];
      sts.is_error = !req_ff.mode[0] && (req_ff.sector_count != spr_ff);
      sts.need_div = (dd != '0);
      sts.div_done = (bit_ff == 6'd0);
      sts.emit = (dd != '0) && (quo_ff[55:32] != '0 || quo_ff[31:0] >= index_ff);
      sts.scale_done = (sc_ff == 3'd3);
   end

   assign rsp_data = '{result_kind: kind_ff, first_sample: first_ff,
      sample_run: run_ff, unique_clean_sectors: res_ff[0],
      unique_dirty_sectors: res_ff[1], read_sectors: res_ff[2],
      write_sectors: res_ff[3]};
endmodule

[rtl/baws_control.sv]
// Controller: sequences latch, division, scaling, update and result handoff
module baws_control import baws_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input logic rsp_stall,
   input sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [8:0] {
      S_CLEAR = 9'b0_0000_0001,
      S_IDLE = 9'b0_0000_0010,
      S_CHECK = 9'b0_0000_0100,
      S_DIV = 9'b0_0000_1000,
      S_DIVLAST = 9'b0_0001_0000,
      S_SCALE = 9'b0_0010_0000,
      S_UPDATE = 9'b0_0100_0000,
      S_OUT = 9'b0_1000_0000,
      S_HALT = 9'b1_0000_0000
   } state_type;
   state_type state_ff, state_in;
   logic fin_ff, fin_in;

   // halted: requests are taken and dropped
   assign req_stall = (state_ff != S_IDLE) && (state_ff != S_HALT);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      fin_in = fin_ff;
      cmd = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.is_final || sts.is_error) begin
               fin_in = 1'b1;
               cmd.final_out = 1'b1;
               state_in = S_SCALE;
            end else if (sts.need_div) begin
               fin_in = 1'b0;
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end else begin
               fin_in = 1'b0;
               state_in = S_UPDATE;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_DIVLAST;
         end
         S_DIVLAST: begin
            if (sts.emit) begin
               cmd.scale = 1'b1;
               state_in = S_SCALE;
            end else begin
               state_in = S_UPDATE;
            end
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            if (sts.scale_done) state_in = fin_ff ? S_OUT : S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in = sts.emit ? S_OUT : S_IDLE;
         end
         S_OUT: begin
            if (!rsp_stall) state_in = fin_ff ? S_HALT : S_IDLE;
         end
         S_HALT: state_in = S_HALT;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         fin_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_ff <= fin_in;
      end
   end
endmodule

[rtl/baws_checker.sv]
// Port checker for the working set sampler
`include "block_access_working_set_sampler_assert.svh"
module baws_checker import baws_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input rsp_type rsp_data
);
   `BAWS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `BAWS_ASSERT_IMPL(a_busy, clock, reset, rsp_valid, req_stall)
   `BAWS_ASSERT_IMPL(a_kind, clock, reset, rsp_valid, rsp_data.result_kind != 2'd3)
   `BAWS_ASSERT_NEXT(a_rsp_once, clock, reset, rsp_valid && !rsp_stall, !rsp_valid)
endmodule

bind block_access_working_set_sampler baws_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

[bench/block_access_working_set_sampler_tb.sv]
// Testbench for the block access working set sampler: table-driven and random requests
module block_access_working_set_sampler_tb;
   import baws_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [55:0] MASK56 = 56'hff_ffff_ffff_ffff;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int NUM_ROWS = 7;
   localparam int NUM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 72;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [0:0] csr_index;
   logic [63:0] csr_data;

   block_access_working_set_sampler i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // predictor state
   logic [1:0] mark_mem [0:65535];
   logic [55:0] trace_start;
   logic [31:0] next_sample;
   logic [31:0] clean_blocks;
   logic [31:0] dirty_blocks;
   logic [31:0] read_accesses;
   logic [31:0] write_accesses;
   bit stopped;
   logic [55:0] quantum;
   logic [7:0] sectors;

   rsp_type pending_samples[$];
   int errors;
   int cycles;
   int samples_seen;
   int requests_sent;
   bit quiet;

   typedef struct {
      req_type r;
      bit typed;
      rsp_type e;
   } row_type;
   row_type rows [NUM_ROWS];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic rsp_type make_sample(logic [1:0] kind, logic [31:0] first,
                                           logic [31:0] run);
      rsp_type o;
      o.result_kind = kind;
      o.first_sample = first;
      o.sample_run = run;
      o.unique_clean_sectors = clean_blocks * sectors;
      o.unique_dirty_sectors = dirty_blocks * sectors;
      o.read_sectors = read_accesses * sectors;
      o.write_sectors = write_accesses * sectors;
      return o;
   endfunction

   function automatic void sample_step(req_type r, output bit has, output rsp_type o);
      logic [55:0] d;
      logic [63:0] q, last, run, nxt;
      logic [1:0] m;
      has = 0;
      o = '0;
      if (stopped) return;
      if (r.mode) begin
         o = make_sample(KIND_FINAL, next_sample, 32'd1);
         has = 1;
         stopped = 1;
         return;
      end
      if (r.sector_count != sectors) begin
         o = make_sample(KIND_ERROR, next_sample, 32'd1);
         has = 1;
         stopped = 1;
         return;
      end
      if (trace_start == 0) trace_start = r.time_stamp;
      d = r.time_stamp - trace_start;
      q = (quantum == 0) ? 64'd1 : {8'd0, quantum};
      if (d != 0) begin
         last = ({8'd0, d} - 64'd1) / q;
         if (last >= {32'd0, next_sample}) begin
            run = last - {32'd0, next_sample} + 64'd1;
            nxt = last + 64'd1;
            if (run > {32'd0, MAX32}) run = {32'd0, MAX32};
            if (nxt > {32'd0, MAX32}) nxt = {32'd0, MAX32};
            o = make_sample(KIND_PERIODIC, next_sample, run[31:0]);
            next_sample = nxt[31:0];
            has = 1;
         end
      end
      m = mark_mem[r.block_address];
      if (r.rw_tag != 0) begin
         if (!(m & MARK_WRITE)) begin
            dirty_blocks++;
            if (m & MARK_READ) clean_blocks--;
         end
         mark_mem[r.block_address] = m | MARK_WRITE;
         write_accesses++;
      end else begin
         if (m == 0) clean_blocks++;
         mark_mem[r.block_address] = m | MARK_READ;
         read_accesses++;
      end
   endfunction

   function automatic int draw_wait();
      return quiet ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", field, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         samples_seen++;
         if (pending_samples.size() == 0) begin
            report("unexpected sample", rsp_data.first_sample, 32'd0);
         end else begin
            w = pending_samples.pop_front();
            if (rsp_data.result_kind !== w.result_kind)
               report("result_kind", 32'(rsp_data.result_kind), 32'(w.result_kind));
            if (rsp_data.first_sample !== w.first_sample)
               report("first_sample", rsp_data.first_sample, w.first_sample);
            if (rsp_data.sample_run !== w.sample_run)
               report("sample_run", rsp_data.sample_run, w.sample_run);
            if (rsp_data.unique_clean_sectors !== w.unique_clean_sectors)
               report("clean", rsp_data.unique_clean_sectors, w.unique_clean_sectors);
            if (rsp_data.unique_dirty_sectors !== w.unique_dirty_sectors)
               report("dirty", rsp_data.unique_dirty_sectors, w.unique_dirty_sectors);
            if (rsp_data.read_sectors !== w.read_sectors)
               report("read", rsp_data.read_sectors, w.read_sectors);
            if (rsp_data.write_sectors !== w.write_sectors)
               report("write", rsp_data.write_sectors, w.write_sectors);
         end
      end
   end

   // result side stall
   initial begin
      int n;
      rsp_stall = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = draw_wait();
         rsp_stall <= (n > 0);
         repeat (n) @(negedge clock);
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send(req_type r, bit typed, rsp_type e);
      int n;
      bit has;
      rsp_type o;
      n = draw_wait();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sample_step(r, has, o);
      if (has) pending_samples.push_back(typed ? e : o);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [63:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_QUANTUM) quantum = value[55:0];
      else sectors = value[7:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type random_record(inout logic [55:0] now);
      req_type r;
      int pick;
      logic [55:0] q;
      q = (quantum == 0) ? 56'd1 : quantum;
      pick = $urandom_range(0, 99);
      if (pick < 40) now = now + 56'({$urandom, $urandom} % ({8'd0, q} / 64'd4 + 64'd1));
      else if (pick < 75) now = now + q + 56'($urandom_range(0, 3));
      else if (pick < 88) now = now + q * 56'($urandom_range(2, 9));
      else if (pick < 93) now = 56'({$urandom, $urandom});
      else if (pick < 97) now = now - 56'($urandom_range(1, 1000));
      else now = '0;
      r.mode = 1'b0;
      r.time_stamp = now;
      r.rw_tag = ($urandom_range(0, 1)) ? 8'd0 : 8'($urandom);
      r.block_address = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 63));
      r.sector_count = sectors;
      return r;
   endfunction

   initial begin
      req_type r;
      rsp_type none;
      logic [55:0] now;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_QUANTUM;
      csr_data = '0;
      errors = 0;
      cycles = 0;
      samples_seen = 0;
      requests_sent = 0;
      quiet = 0;
      none = '0;
      for (int a = 0; a < 65536; a++) mark_mem[a] = 2'b00;
      trace_start = 0;
      next_sample = 1;
      clean_blocks = 0;
      dirty_blocks = 0;
      read_accesses = 0;
      write_accesses = 0;
      stopped = 0;
      quantum = QUANTUM_RESET;
      sectors = SECTORS_RESET;

      rows[0] = '{'{1'b0, 56'd0, 8'd0, 16'h0000, 8'd8}, 0, none};
      rows[1] = '{'{1'b0, 56'd100, 8'h80, 16'h0000, 8'd8}, 0, none};
      rows[2] = '{'{1'b0, 56'd4000000101, 8'd0, 16'hffff, 8'd8}, 1,
                  '{KIND_PERIODIC, 32'd1, 32'd2, 32'd0, 32'd8, 32'd8, 32'd8}};
      rows[3] = '{'{1'b0, 56'd50, 8'h01, 16'hffff, 8'd8}, 0, none};
      rows[4] = '{'{1'b0, MASK56, 8'hff, 16'h1234, 8'd8}, 0, none};
      rows[5] = '{'{1'b0, MASK56, 8'd0, 16'h5555, 8'd8}, 0, none};
      rows[6] = '{'{1'b0, 56'h55_5555_5555_5555, 8'h7e, 16'haaaa, 8'd8}, 0, none};

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (rows[i]) send(rows[i].r, rows[i].typed, rows[i].e);
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin
               write_csr(CSR_QUANTUM, 64'd1000);
               write_csr(CSR_SECTORS, 64'd1);
            end
            1: begin
               write_csr(CSR_QUANTUM, 64'd0);
               write_csr(CSR_SECTORS, 64'd255);
            end
            2: begin
               write_csr(CSR_QUANTUM, {8'd0, MASK56});
               write_csr(CSR_SECTORS, 64'($urandom_range(1, 255)));
            end
            3: begin
               write_csr(CSR_QUANTUM, 64'($urandom_range(1, 5000)));
               write_csr(CSR_SECTORS, 64'($urandom_range(1, 255)));
            end
            4: begin
               write_csr(CSR_QUANTUM, 64'd2000000000);
               write_csr(CSR_SECTORS, 64'd8);
            end
            default: begin
               write_csr(CSR_QUANTUM, 64'($urandom_range(1, 200)));
               write_csr(CSR_SECTORS, 64'($urandom_range(1, 255)));
            end
         endcase
         now = trace_start;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if ($urandom_range(0, 39) == 0) quiet = !quiet;
            r = random_record(now);
            send(r, 0, none);
         end
         drain();
      end

      // one halting request closes the trace
      r = random_record(now);
      if ($urandom_range(0, 1)) r.mode = 1'b1;
      else r.sector_count = sectors ^ 8'($urandom_range(1, 255));
      send(r, 0, none);
      // requests after the halt are taken and give nothing
      for (int k = 0; k < 3; k++) begin
         r = random_record(now);
         send(r, 0, none);
      end
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);

      $display("covered %0d requests and %0d samples over %0d settings",
               requests_sent, samples_seen, NUM_PHASES + 1);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
